>>> src/sorted_insert_priority_queue_unit_assert.svh
// Assertion macros for the sorted-insert priority queue.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SPIQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SPIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/spiq_pkg.sv
`timescale 1ns / 1ps

package spiq_pkg;

    // Default sizes
    localparam int CAPACITY_DEF      = 16;
    localparam int DATA_BITS_DEF     = 32;
    localparam int PRIORITY_BITS_DEF = 8;

    // Operation kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Order modes
    localparam logic MODE_LARGER_BETTER  = 1'b0;
    localparam logic MODE_SMALLER_BETTER = 1'b1;

    // Control broadcast to every cell in the chain
    typedef struct packed {
        logic enq;
        logic deq;
        logic mode;
    } cell_ctrl_t;

endpackage

>>> src/spiq_if.sv
`timescale 1ns / 1ps

// Request channel: one operation word
interface spiq_req_if #(
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 8
);
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [DATA_BITS-1:0]     item_data;
    logic [PRIORITY_BITS-1:0] item_priority;

    modport source (output valid, kind, item_data, item_priority, input ready);
    modport sink   (input valid, kind, item_data, item_priority, output ready);
endinterface

// Response channel: one result word
interface spiq_rsp_if #(
    parameter int DATA_BITS = 32,
    parameter int OCC_BITS  = 5
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [DATA_BITS-1:0] out_data;
    logic [OCC_BITS-1:0]  occupancy;

    modport source (output valid, status, out_data, occupancy, input ready);
    modport sink   (input valid, status, out_data, occupancy, output ready);
endinterface

// Configuration channel: order mode write
interface spiq_cfg_if;
    logic valid;
    logic ready;
    logic order_mode;

    modport source (output valid, order_mode, input ready);
    modport sink   (input valid, order_mode, output ready);
endinterface

>>> src/spiq_cell.sv
`timescale 1ns / 1ps

module spiq_cell #(
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  spiq_pkg::cell_ctrl_t     ctrl,
    input  logic [DATA_BITS-1:0]     new_data,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic                     hit_in,
    input  logic                     left_valid,
    input  logic [DATA_BITS-1:0]     left_data,
    input  logic [PRIORITY_BITS-1:0] left_prio,
    input  logic                     right_valid,
    input  logic [DATA_BITS-1:0]     right_data,
    input  logic [PRIORITY_BITS-1:0] right_prio,
    output logic                     valid,
    output logic [DATA_BITS-1:0]     data,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic                     hit_out
);
    import spiq_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic [DATA_BITS-1:0]     data_reg;
    logic [DATA_BITS-1:0]     data_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;
    logic                     beats;
    logic                     take_new;

    // Compare the incoming priority against the one held here
    always_comb
    begin
        unique case (ctrl.mode)
            MODE_SMALLER_BETTER: beats = (new_prio <= prio_reg);
            default:             beats = (new_prio >= prio_reg);
        endcase
    end

    // An empty cell also ends the search: the new entry lands at the rear
    assign take_new = !hit_in && (!valid_reg || beats);
    assign hit_out  = hit_in || !valid_reg || beats;

    // Pick the next content: shift rear, shift front, load or hold
    always_comb
    begin
        priority if (ctrl.enq && hit_in)
        begin
            valid_next = left_valid;
            data_next  = left_data;
            prio_next  = left_prio;
        end
        else if (ctrl.enq && take_new)
        begin
            valid_next = 1'b1;
            data_next  = new_data;
            prio_next  = new_prio;
        end
        else if (ctrl.deq)
        begin
            valid_next = right_valid;
            data_next  = right_data;
            prio_next  = right_prio;
        end
        else
        begin
            valid_next = valid_reg;
            data_next  = data_reg;
            prio_next  = prio_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign prio  = prio_reg;

endmodule

>>> src/sorted_insert_priority_queue_unit.sv
`timescale 1ns / 1ps

// Sorted-insert priority queue built as a row of CAPACITY cells, best entry in
// cell 0. Every cell compares the incoming priority with its own in the same
// cycle, and a hit signal ripples down the row so that the first cell whose
// entry the new one equals or beats (or the first empty cell) loads it while
// all cells behind it shift one place to the rear; a dequeue shifts the whole
// row one place to the front. One request word is taken per clock cycle and
// its response word appears in the output register in the next cycle; a
// stalled response holds the request side only while the output register is
// full and not being drained. The ripple of the hit signal through the row
// sets the critical path. order_mode takes effect on the next enqueue and
// does not reorder stored entries.

`include "sorted_insert_priority_queue_unit_assert.svh"

module sorted_insert_priority_queue_unit #(
    parameter int CAPACITY      = spiq_pkg::CAPACITY_DEF,
    parameter int DATA_BITS     = spiq_pkg::DATA_BITS_DEF,
    parameter int PRIORITY_BITS = spiq_pkg::PRIORITY_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    spiq_req_if.sink   req,
    spiq_rsp_if.source rsp,
    spiq_cfg_if.sink   cfg
);
    import spiq_pkg::*;

    localparam int OCC_BITS = $clog2(CAPACITY + 1);

    logic                     mode_reg;
    logic [OCC_BITS-1:0]      count_reg;
    logic [OCC_BITS-1:0]      count_next;
    logic                     rsp_valid_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [DATA_BITS-1:0]     rsp_data_reg;
    logic [DATA_BITS-1:0]     rsp_data_next;
    logic [OCC_BITS-1:0]      occ_reg;

    logic                     fire;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;

    logic [CAPACITY-1:0]      cell_valid;
    logic [DATA_BITS-1:0]     cell_data [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
    logic [CAPACITY:0]        hit;
    logic                     valid_packed;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LARGER_BETTER;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.order_mode;
        end
    end

    // Accept a request whenever the output register is free or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = cell_valid[CAPACITY-1];
    assign empty     = !cell_valid[0];

    assign ctrl.enq  = fire && (req.kind == KIND_ENQ) && !full;
    assign ctrl.deq  = fire && (req.kind == KIND_DEQ) && !empty;
    assign ctrl.mode = mode_reg;

    // Cell row
    assign hit[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                     lv;
            logic [DATA_BITS-1:0]     ld;
            logic [PRIORITY_BITS-1:0] lp;
            logic                     rv;
            logic [DATA_BITS-1:0]     rd;
            logic [PRIORITY_BITS-1:0] rp;

            if (i == 0)
            begin : g_front
                assign lv = 1'b0;
                assign ld = '0;
                assign lp = '0;
            end
            else
            begin : g_mid_l
                assign lv = cell_valid[i-1];
                assign ld = cell_data[i-1];
                assign lp = cell_prio[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_rear
                assign rv = 1'b0;
                assign rd = '0;
                assign rp = '0;
            end
            else
            begin : g_mid_r
                assign rv = cell_valid[i+1];
                assign rd = cell_data[i+1];
                assign rp = cell_prio[i+1];
            end

            spiq_cell #(
                .DATA_BITS     (DATA_BITS),
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_data    (req.item_data),
                .new_prio    (req.item_priority),
                .hit_in      (hit[i]),
                .left_valid  (lv),
                .left_data   (ld),
                .left_prio   (lp),
                .right_valid (rv),
                .right_data  (rd),
                .right_prio  (rp),
                .valid       (cell_valid[i]),
                .data        (cell_data[i]),
                .prio        (cell_prio[i]),
                .hit_out     (hit[i+1])
            );
        end
    endgenerate

    // Occupancy count
    always_comb
    begin
        priority if (ctrl.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Response word
    always_comb
    begin
        status_next   = ST_OK;
        rsp_data_next = '0;
        priority if (req.kind == KIND_ENQ && full)
        begin
            status_next = ST_FULL;
        end
        else if (req.kind == KIND_DEQ && empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (req.kind == KIND_DEQ)
        begin
            rsp_data_next = cell_data[0];
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the response payload until a new word is taken
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status_next;
            rsp_data_reg <= rsp_data_next;
            occ_reg      <= count_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.out_data  = rsp_data_reg;
    assign rsp.occupancy = occ_reg;

    // Valid cells must form an unbroken run from the front
    assign valid_packed = ((cell_valid + 1'b1) & cell_valid) == '0;

    `SPIQ_ASSERT_NOW(a_count_matches, clk, rst_n, 1'b1,
        count_reg == OCC_BITS'($countones(cell_valid)), "count disagrees with cells")
    `SPIQ_ASSERT_NOW(a_valid_packed, clk, rst_n, 1'b1, valid_packed,
        "gap in the cell row")
    `SPIQ_ASSERT_NEXT(a_enq_grows, clk, rst_n, ctrl.enq,
        count_reg == $past(count_reg) + 1'b1, "enqueue did not add an entry")
    `SPIQ_ASSERT_NOW(a_full_occ, clk, rst_n, rsp.valid && rsp.status == ST_FULL,
        rsp.occupancy == OCC_BITS'(CAPACITY), "full status with room left")

endmodule
